@@ src/hmf_pkg.sv @@
// Shared constants and types for the histogram mode finder.
package hmf_pkg;

    localparam int VALUE_BITS_DEF = 8;
    localparam int COUNT_BITS_DEF = 16;
    localparam int EPOCH_BITS     = 8;
    localparam int QUEUE_DEPTH    = 4;
    localparam int OUT_DEPTH      = 4;
    localparam int SAMPLE_W       = 8;
    localparam int MCOUNT_W       = 16;

    typedef struct packed {
        logic                first;
        logic                last;
        logic [SAMPLE_W-1:0] value;
    } hmf_item_t;

    typedef struct packed {
        logic [SAMPLE_W-1:0] mode_value;
        logic [MCOUNT_W-1:0] mode_count;
    } hmf_result_t;

    typedef enum logic [1:0] {
        BK_CLEAR = 2'b01,
        BK_RUN   = 2'b10
    } hmf_bk_state_t;

endpackage

@@ src/hmf_if.sv @@
// Valid/ready channel interfaces for samples in and modes out.
interface hmf_in_if
    import hmf_pkg::*;
();
    logic                valid;
    logic                ready;
    logic [SAMPLE_W-1:0] sample_value;
    logic                is_last;

    modport source (output valid, output sample_value, output is_last, input ready);
    modport sink   (input valid, input sample_value, input is_last, output ready);
endinterface

interface hmf_out_if
    import hmf_pkg::*;
();
    logic                valid;
    logic                ready;
    logic [SAMPLE_W-1:0] mode_value;
    logic [MCOUNT_W-1:0] mode_count;

    modport source (output valid, output mode_value, output mode_count, input ready);
    modport sink   (input valid, input mode_value, input mode_count, output ready);
endinterface

@@ src/hmf_fifo.sv @@
// Small register FIFO with occupancy count.
module hmf_fifo
    import hmf_pkg::*;
#(
    parameter int WIDTH = 1,
    parameter int DEPTH = QUEUE_DEPTH
)
(
    input  logic                       clk,
    input  logic                       rst_n,
    input  logic                       push,
    input  logic [WIDTH-1:0]           push_data,
    output logic                       full,
    input  logic                       pop,
    output logic [WIDTH-1:0]           pop_data,
    output logic                       empty,
    output logic [$clog2(DEPTH+1)-1:0] count
);

    localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W = $clog2(DEPTH + 1);

    logic [WIDTH-1:0] mem_reg [DEPTH];
    logic [PTR_W-1:0] wr_ptr_reg;
    logic [PTR_W-1:0] wr_ptr_next;
    logic [PTR_W-1:0] rd_ptr_reg;
    logic [PTR_W-1:0] rd_ptr_next;
    logic [CNT_W-1:0] count_reg;
    logic [CNT_W-1:0] count_next;
    logic             do_push;
    logic             do_pop;

    assign full     = (count_reg == CNT_W'(DEPTH));
    assign empty    = (count_reg == '0);
    assign count    = count_reg;
    assign pop_data = mem_reg[rd_ptr_reg];
    assign do_push  = push && !full;
    assign do_pop   = pop && !empty;

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        if (do_push)
        begin
            wr_ptr_next = (wr_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
        end
        if (do_pop)
        begin
            rd_ptr_next = (rd_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;
        end
        count_next = count_reg + CNT_W'(do_push) - CNT_W'(do_pop);
    end

    always_ff @(posedge clk)
    begin
        if (do_push)
        begin
            mem_reg[wr_ptr_reg] <= push_data;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

endmodule

@@ src/hmf_front.sv @@
// Front end: accepts samples and tags the first and last item of each set.
module hmf_front
    import hmf_pkg::*;
(
    input  logic      clk,
    input  logic      rst_n,
    hmf_in_if.sink    samples,
    input  logic      clearing,
    input  logic      q_full,
    output logic      q_push,
    output hmf_item_t q_item
);

    logic at_set_start_reg;
    logic at_set_start_next;

    assign samples.ready = !q_full && !clearing;
    assign q_push        = samples.valid && samples.ready;

    always_comb
    begin
        q_item.first      = at_set_start_reg;
        q_item.last       = samples.is_last;
        q_item.value      = samples.sample_value;
        at_set_start_next = q_push ? samples.is_last : at_set_start_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            at_set_start_reg <= 1'b1;
        end
        else
        begin
            at_set_start_reg <= at_set_start_next;
        end
    end

endmodule

@@ src/hmf_back.sv @@
// Back end: counter memory read-modify-write, running best, epoch clearing.
module hmf_back
    import hmf_pkg::*;
#(
    parameter int VALUE_BITS = VALUE_BITS_DEF,
    parameter int COUNT_BITS = COUNT_BITS_DEF
)
(
    input  logic                           clk,
    input  logic                           rst_n,
    input  logic                           q_empty,
    input  hmf_item_t                      q_item,
    output logic                           q_pop,
    input  logic [$clog2(OUT_DEPTH+1)-1:0] out_count,
    output logic                           res_push,
    output hmf_result_t                    res_data,
    output logic                           clearing
);

    localparam int DEPTH  = 1 << VALUE_BITS;
    localparam int WORD_W = COUNT_BITS + EPOCH_BITS;
    localparam int VWIDE  = (VALUE_BITS > SAMPLE_W) ? VALUE_BITS : SAMPLE_W;
    localparam int CWIDE  = (COUNT_BITS > MCOUNT_W) ? COUNT_BITS : MCOUNT_W;

    logic [WORD_W-1:0]     count_mem [DEPTH];

    hmf_bk_state_t         state_reg;
    hmf_bk_state_t         state_next;
    logic [VALUE_BITS-1:0] clr_addr_reg;
    logic [VALUE_BITS-1:0] clr_addr_next;
    logic [EPOCH_BITS-1:0] epoch_reg;
    logic [EPOCH_BITS-1:0] epoch_next;

    logic                  st_valid_reg;
    logic                  st_first_reg;
    logic                  st_last_reg;
    logic                  st_hit_reg;
    logic                  st_hit_next;
    logic [VALUE_BITS-1:0] st_val_reg;
    logic [COUNT_BITS-1:0] fwd_reg;
    logic [WORD_W-1:0]     rd_reg;

    logic [VALUE_BITS-1:0] best_value_reg;
    logic [VALUE_BITS-1:0] best_value_next;
    logic [COUNT_BITS-1:0] best_count_reg;
    logic [COUNT_BITS-1:0] best_count_next;
    logic [VALUE_BITS-1:0] first_reg;
    logic [VALUE_BITS-1:0] first_next;

    logic [VWIDE-1:0]      head_wide;
    logic [VALUE_BITS-1:0] head_val;
    logic [EPOCH_BITS-1:0] rd_tag;
    logic [COUNT_BITS-1:0] rd_cnt;
    logic [COUNT_BITS-1:0] c_old;
    logic [COUNT_BITS-1:0] c_new;
    logic [VALUE_BITS-1:0] first_eff;
    logic [VALUE_BITS-1:0] upd_value;
    logic [COUNT_BITS-1:0] upd_count;
    logic [VWIDE-1:0]      out_value_wide;
    logic [CWIDE-1:0]      out_count_wide;
    logic                  set_done;
    logic                  wrap_hold;
    logic                  credit_ok;
    logic                  mem_we;
    logic [VALUE_BITS-1:0] mem_addr;
    logic [WORD_W-1:0]     mem_wdata;

    assign head_wide = VWIDE'(q_item.value);
    assign head_val  = head_wide[VALUE_BITS-1:0];
    assign rd_tag    = rd_reg[COUNT_BITS +: EPOCH_BITS];
    assign rd_cnt    = rd_reg[COUNT_BITS-1:0];
    assign set_done  = st_valid_reg && st_last_reg;
    assign clearing  = (state_reg == BK_CLEAR);

    // epoch about to wrap: stop issuing until the store is swept
    assign wrap_hold = set_done && (&epoch_reg);
    assign credit_ok = (int'(out_count) + int'(set_done)) < OUT_DEPTH;
    assign q_pop     = !q_empty && (state_reg == BK_RUN) && !wrap_hold
                       && (!q_item.last || credit_ok);

    always_comb
    begin
        if (st_hit_reg)
        begin
            c_old = fwd_reg;
        end
        else if (rd_tag == epoch_reg)
        begin
            c_old = rd_cnt;
        end
        else
        begin
            c_old = '0;
        end
        c_new     = (&c_old) ? c_old : c_old + 1'b1;
        first_eff = st_first_reg ? st_val_reg : first_reg;

        upd_value = best_value_reg;
        upd_count = best_count_reg;
        if (c_new > best_count_reg)
        begin
            upd_value = st_val_reg;
            upd_count = c_new;
        end
        else if ((c_new == best_count_reg) && (st_val_reg == first_eff))
        begin
            upd_value = st_val_reg;
        end

        best_value_next = best_value_reg;
        best_count_next = best_count_reg;
        first_next      = first_reg;
        epoch_next      = epoch_reg;
        if (st_valid_reg)
        begin
            first_next = first_eff;
            if (st_last_reg)
            begin
                best_value_next = '0;
                best_count_next = '0;
                epoch_next      = epoch_reg + 1'b1;
            end
            else
            begin
                best_value_next = upd_value;
                best_count_next = upd_count;
            end
        end

        st_hit_next = q_pop && st_valid_reg && !st_last_reg && (st_val_reg == head_val);
    end

    assign out_value_wide      = VWIDE'(upd_value);
    assign out_count_wide      = CWIDE'(upd_count);
    assign res_push            = set_done;
    assign res_data.mode_value = out_value_wide[SAMPLE_W-1:0];
    assign res_data.mode_count = out_count_wide[MCOUNT_W-1:0];

    always_comb
    begin
        state_next    = state_reg;
        clr_addr_next = '0;
        case (state_reg)
            BK_CLEAR:
            begin
                clr_addr_next = clr_addr_reg + 1'b1;
                if (&clr_addr_reg)
                begin
                    state_next = BK_RUN;
                end
            end
            BK_RUN:
            begin
                if (wrap_hold)
                begin
                    state_next = BK_CLEAR;
                end
            end
            default:
            begin
                state_next = BK_CLEAR;
            end
        endcase
    end

    always_comb
    begin
        mem_we    = clearing || st_valid_reg;
        mem_addr  = clearing ? clr_addr_reg : st_val_reg;
        mem_wdata = clearing ? '0 : {epoch_reg, c_new};
    end

    always_ff @(posedge clk)
    begin
        if (mem_we)
        begin
            count_mem[mem_addr] <= mem_wdata;
        end
        rd_reg <= count_mem[head_val];
    end

    always_ff @(posedge clk)
    begin
        st_first_reg <= q_item.first;
        st_last_reg  <= q_item.last;
        st_val_reg   <= head_val;
        fwd_reg      <= c_new;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= BK_CLEAR;
            clr_addr_reg   <= '0;
            epoch_reg      <= '0;
            st_valid_reg   <= 1'b0;
            st_hit_reg     <= 1'b0;
            best_value_reg <= '0;
            best_count_reg <= '0;
            first_reg      <= '0;
        end
        else
        begin
            state_reg      <= state_next;
            clr_addr_reg   <= clr_addr_next;
            epoch_reg      <= epoch_next;
            st_valid_reg   <= q_pop;
            st_hit_reg     <= st_hit_next;
            best_value_reg <= best_value_next;
            best_count_reg <= best_count_next;
            first_reg      <= first_next;
        end
    end

endmodule

@@ src/histogram_mode_finder.sv @@
// Histogram mode finder: one sample per cycle unless stalled, emits mode value and count per set.
// Result path: input queue, issue stage register, then the output buffer offers the set's result.
// Throughput: one item per cycle unless stalled, bound by the counter memory's read and write port.
// Reset: asynchronous active low; a clearing pass over all 2^VALUE_BITS addresses follows reset
// and every 256th set, with samples.ready held low meanwhile.
module histogram_mode_finder
    import hmf_pkg::*;
#(
    parameter int VALUE_BITS = VALUE_BITS_DEF,
    parameter int COUNT_BITS = COUNT_BITS_DEF
)
(
    input  logic      clk,
    input  logic      rst_n,
    hmf_in_if.sink    samples,
    hmf_out_if.source modes
);

    localparam int ITEM_W = $bits(hmf_item_t);
    localparam int RES_W  = $bits(hmf_result_t);

    logic                           q_push;
    logic                           q_pop;
    logic                           q_full;
    logic                           q_empty;
    hmf_item_t                      q_in;
    hmf_item_t                      q_item;
    logic [$clog2(QUEUE_DEPTH+1)-1:0] q_count;
    logic                           clearing;
    logic                           res_push;
    hmf_result_t                    res_data;
    hmf_result_t                    out_data;
    logic                           out_full;
    logic                           out_empty;
    logic                           out_pop;
    logic [$clog2(OUT_DEPTH+1)-1:0] out_count;

    hmf_front u_front
    (
        .clk      (clk),
        .rst_n    (rst_n),
        .samples  (samples),
        .clearing (clearing),
        .q_full   (q_full),
        .q_push   (q_push),
        .q_item   (q_in)
    );

    hmf_fifo #(.WIDTH(ITEM_W), .DEPTH(QUEUE_DEPTH)) u_queue
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (q_push),
        .push_data (q_in),
        .full      (q_full),
        .pop       (q_pop),
        .pop_data  (q_item),
        .empty     (q_empty),
        .count     (q_count)
    );

    hmf_back #(.VALUE_BITS(VALUE_BITS), .COUNT_BITS(COUNT_BITS)) u_back
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .q_empty   (q_empty),
        .q_item    (q_item),
        .q_pop     (q_pop),
        .out_count (out_count),
        .res_push  (res_push),
        .res_data  (res_data),
        .clearing  (clearing)
    );

    hmf_fifo #(.WIDTH(RES_W), .DEPTH(OUT_DEPTH)) u_out
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (res_push),
        .push_data (res_data),
        .full      (out_full),
        .pop       (out_pop),
        .pop_data  (out_data),
        .empty     (out_empty),
        .count     (out_count)
    );

    assign out_pop          = modes.valid && modes.ready;
    assign modes.valid      = !out_empty;
    assign modes.mode_value = out_data.mode_value;
    assign modes.mode_count = out_data.mode_count;

`ifndef SYNTHESIS
    a_queue_no_overflow: assert property (@(posedge clk) disable iff (!rst_n)
        !(q_push && q_full))
        else $error("item pushed into full queue");

    a_out_no_overflow: assert property (@(posedge clk) disable iff (!rst_n)
        !(res_push && out_full))
        else $error("result pushed into full output buffer");

    a_no_issue_in_clear: assert property (@(posedge clk) disable iff (!rst_n)
        !(q_pop && clearing))
        else $error("item issued during clearing pass");

    a_last_gives_result: assert property (@(posedge clk) disable iff (!rst_n)
        (q_pop && q_item.last) |=> res_push)
        else $error("last item issued without a result");

    a_queue_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
        (q_full && !q_pop) |=> !q_empty)
        else $error("full queue emptied without issue");
`endif

endmodule

@@ tb/tb_histogram_mode_finder.sv @@
`timescale 1ns / 1ps
// Testbench for histogram_mode_finder: directed table plus random data sets, scored by a predictor.
module tb_histogram_mode_finder;
    import hmf_pkg::*;

    localparam int VB        = VALUE_BITS_DEF;
    localparam int DEPTH     = 1 << VB;
    localparam logic [31:0] COUNT_TOP = 32'hFFFF_FFFF >> (32 - COUNT_BITS_DEF);
    localparam int LIMIT     = 1_000_000;
    localparam int PHASE_ITEMS = 550;

    typedef enum int {SPREAD, CLUSTER, PAIR} set_shape_t;

    typedef struct {
        logic [7:0]  sval;
        bit          last;
        int          reps;
        bit          typed;
        logic [7:0]  exp_value;
        logic [15:0] exp_count;
    } stim_row_t;

    logic clk = 1'b0;
    logic rst_n;

    hmf_in_if  samples();
    hmf_out_if modes();

    histogram_mode_finder DUT (
        .clk     (clk),
        .rst_n   (rst_n),
        .samples (samples),
        .modes   (modes)
    );

    always
    begin
        #2 clk = 1'b1;
        #2 clk = 1'b0;
    end

    // predictor state
    logic [31:0]   tally [DEPTH];
    logic [VB-1:0] best_value;
    logic [31:0]   best_count;
    logic [VB-1:0] lead_value;
    bit            at_set_start;

    hmf_result_t   expected_modes [$];
    int            errors;
    int            cycles;
    int            idle_pct;
    int            stall_pct;

    // typed expectation travels with the item it belongs to
    bit            row_typed;
    logic [7:0]    row_exp_value;
    logic [15:0]   row_exp_count;

    stim_row_t directed [] = '{
        '{8'h00, 1'b1, 1,        1'b1, 8'h00, 16'd1},
        '{8'hFF, 1'b1, 1,        1'b1, 8'hFF, 16'd1},
        '{8'h80, 1'b0, 1,        1'b0, 8'h00, 16'd0},
        '{8'h01, 1'b0, 1,        1'b0, 8'h00, 16'd0},
        '{8'h01, 1'b1, 1,        1'b1, 8'h01, 16'd2},
        // tie, first value of the set is among the tied
        '{8'h05, 1'b0, 1,        1'b0, 8'h00, 16'd0},
        '{8'h09, 1'b0, 2,        1'b0, 8'h00, 16'd0},
        '{8'h05, 1'b1, 1,        1'b0, 8'h00, 16'd0},
        // tie, earliest to reach the count wins
        '{8'h01, 1'b0, 1,        1'b0, 8'h00, 16'd0},
        '{8'h07, 1'b0, 1,        1'b0, 8'h00, 16'd0},
        '{8'h08, 1'b0, 2,        1'b0, 8'h00, 16'd0},
        '{8'h07, 1'b1, 1,        1'b0, 8'h00, 16'd0}
    };

    function automatic void clear_tally();
        for (int i = 0; i < DEPTH; i++)
        begin
            tally[i] = '0;
        end
        best_value   = '0;
        best_count   = '0;
        lead_value   = '0;
        at_set_start = 1'b1;
    endfunction

    function automatic bit tally_sample(input logic [7:0] sval, input logic last,
                                        output hmf_result_t mode);
        logic [VB-1:0] v;
        logic [31:0]   c;
        v = sval[VB-1:0];
        mode = '0;
        if (at_set_start)
        begin
            lead_value   = v;
            at_set_start = 1'b0;
        end
        c = tally[v];
        if (c < COUNT_TOP)
        begin
            c = c + 1;
        end
        tally[v] = c;
        if (c > best_count)
        begin
            best_value = v;
            best_count = c;
        end
        else if (c == best_count && v == lead_value)
        begin
            best_value = v;
        end
        if (!last)
        begin
            return 1'b0;
        end
        mode.mode_value = 8'(best_value);
        mode.mode_count = best_count[15:0];
        clear_tally();
        return 1'b1;
    endfunction

    task automatic note_mismatch(input string what, input int unsigned exp_v,
                                 input int unsigned act_v);
        errors++;
        if (errors <= 10)
        begin
            $display("mismatch %s: expected %0h got %0h", what, exp_v, act_v);
        end
    endtask

    task automatic offer_sample(input logic [7:0] sval, input bit last, input bit typed,
                                input logic [7:0] exp_value, input logic [15:0] exp_count);
        while ($urandom_range(0, 99) < idle_pct)
        begin
            samples.valid <= 1'b0;
            @(posedge clk);
        end
        samples.valid        <= 1'b1;
        samples.sample_value <= sval;
        samples.is_last      <= last;
        row_typed            <= typed;
        row_exp_value        <= exp_value;
        row_exp_count        <= exp_count;
        do
            @(posedge clk);
        while (samples.ready !== 1'b1);
    endtask

    // scoreboard: input side first, so an expectation is queued before any check at that edge
    always @(posedge clk)
    begin
        hmf_result_t mode;
        hmf_result_t want;
        if (rst_n && samples.valid && samples.ready)
        begin
            if (tally_sample(samples.sample_value, samples.is_last, mode))
            begin
                if (row_typed)
                begin
                    mode.mode_value = row_exp_value;
                    mode.mode_count = row_exp_count;
                end
                expected_modes.push_back(mode);
            end
        end
        if (rst_n && modes.valid && modes.ready)
        begin
            if (expected_modes.size() == 0)
            begin
                note_mismatch("unexpected item, mode_value", 0, modes.mode_value);
            end
            else
            begin
                want = expected_modes.pop_front();
                if (modes.mode_value !== want.mode_value)
                begin
                    note_mismatch("mode_value", want.mode_value, modes.mode_value);
                end
                if (modes.mode_count !== want.mode_count)
                begin
                    note_mismatch("mode_count", want.mode_count, modes.mode_count);
                end
            end
        end
    end

    always @(posedge clk)
    begin
        modes.ready <= ($urandom_range(0, 99) >= stall_pct);
    end

    always @(posedge clk)
    begin
        cycles <= cycles + 1;
        if (cycles == LIMIT)
        begin
            $display("status: fail");
            $finish;
        end
    end

    initial
    begin
        int         sent;
        int         len;
        set_shape_t shape;
        logic [7:0] base;
        logic [7:0] v;
        int         idle_by_phase [3];
        int         stall_by_phase [3];

        idle_by_phase  = '{25, 80, 0};
        stall_by_phase = '{80, 25, 0};
        rst_n                = 1'b0;
        samples.valid        = 1'b0;
        samples.sample_value = '0;
        samples.is_last      = 1'b0;
        modes.ready          = 1'b0;
        row_typed            = 1'b0;
        row_exp_value        = '0;
        row_exp_count        = '0;
        errors               = 0;
        cycles               = 0;
        idle_pct             = idle_by_phase[0];
        stall_pct            = stall_by_phase[0];
        clear_tally();

        repeat (6) @(posedge clk);
        rst_n <= 1'b1;

        foreach (directed[i])
        begin
            for (int r = 0; r < directed[i].reps; r++)
            begin
                offer_sample(directed[i].sval,
                             directed[i].last && (r == directed[i].reps - 1),
                             directed[i].typed, directed[i].exp_value,
                             directed[i].exp_count);
            end
        end

        for (int ph = 0; ph < 3; ph++)
        begin
            idle_pct  = idle_by_phase[ph];
            stall_pct = stall_by_phase[ph];
            sent = 0;
            while (sent < PHASE_ITEMS)
            begin
                len   = ($urandom_range(0, 24) == 0) ? $urandom_range(9, 40)
                                                     : $urandom_range(1, 8);
                shape = set_shape_t'($urandom_range(0, 2));
                base  = 8'($urandom_range(0, 255));
                for (int k = 0; k < len; k++)
                begin
                    case (shape)
                        SPREAD:  v = 8'($urandom_range(0, 255));
                        CLUSTER: v = base ^ 8'($urandom_range(0, 3));
                        default: v = (k == 0 || $urandom_range(0, 1) == 1) ? base : ~base;
                    endcase
                    offer_sample(v, k == len - 1, 1'b0, '0, '0);
                end
                sent += len;
            end
        end
        samples.valid <= 1'b0;

        while (expected_modes.size() != 0)
        begin
            @(posedge clk);
        end
        repeat (10) @(posedge clk);

        if (errors == 0 && expected_modes.size() == 0)
        begin
            $display("status: pass");
        end
        else
        begin
            $display("status: fail");
        end
        $finish;
    end

endmodule
